// ===== design/page_frame_bitmap_allocator_assert.svh =====
// Assertion macros used by the page frame allocator datapath.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PFBA_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pfba: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PFBA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pfba: next-cycle check failed");

`endif

// ===== design/pfba_pkg.sv =====
// Shared types and constants of the page frame bitmap allocator.
package pfba_pkg;

    localparam int NUM_FRAMES  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int FRAME_W     = 5;
    localparam int COUNT_W     = 6;
    localparam int STATUS_W    = 2;

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED   = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [COUNT_W-1:0] page_count;
        logic [FRAME_W-1:0] frame_to_free;
    } t_in_req;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_out_res;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic alloc_ok;
        logic grant_last;
    } t_dp_status;

endpackage

// ===== design/pfba_ctrl.sv =====
// Controller state machine: idle for new requests, scan while granting frames.
module pfba_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  pfba_pkg::t_dp_status  i_status,
    output pfba_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_stall
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    // Take a request only when idle and the result register can take a result
    assign o_in_stall   = !((r_state == S_IDLE) && i_status.out_free);
    assign o_cmd.accept = (r_state == S_IDLE) && i_status.out_free && i_in_valid;
    assign o_cmd.step   = (r_state == S_SCAN) && i_status.out_free;

    // Advance the state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_status.alloc_ok) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (o_cmd.step && i_status.grant_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/pfba_dp.sv =====
// Datapath: used-frame bitmap, free count, scan pointer and result register.
`include "page_frame_bitmap_allocator_assert.svh"

module pfba_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfba_pkg::t_in_req     i_in_data,
    input  logic                  i_out_stall,
    input  pfba_pkg::t_dp_cmd     i_cmd,
    output pfba_pkg::t_dp_status  o_status,
    output logic                  o_out_valid,
    output pfba_pkg::t_out_res    o_out_data
);

    logic [pfba_pkg::NUM_FRAMES-1:0] r_used_map;
    logic [pfba_pkg::NUM_FRAMES-1:0] n_used_map;
    logic [pfba_pkg::COUNT_W-1:0]    r_free_count;
    logic [pfba_pkg::COUNT_W-1:0]    n_free_count;
    logic [pfba_pkg::FRAME_W-1:0]    r_scan_idx;
    logic [pfba_pkg::FRAME_W-1:0]    n_scan_idx;
    logic [pfba_pkg::COUNT_W-1:0]    r_remaining;
    logic [pfba_pkg::COUNT_W-1:0]    n_remaining;
    logic                            r_out_valid;
    logic                            n_out_valid;
    pfba_pkg::t_out_res              r_out;
    pfba_pkg::t_out_res              n_out;
    logic                            w_scan_free;

    // Status back to the controller
    assign w_scan_free       = !r_used_map[r_scan_idx];
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_status.alloc_ok = (i_in_data.cmd == pfba_pkg::CMD_ALLOC)
                            && (i_in_data.page_count != '0)
                            && (i_in_data.page_count
                                <= pfba_pkg::COUNT_W'(pfba_pkg::MAX_RESULTS))
                            && (i_in_data.page_count <= r_free_count);
    assign o_status.grant_last = w_scan_free
                              && (r_remaining == pfba_pkg::COUNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Update bitmap, count and result register
    always_comb begin
        n_used_map   = r_used_map;
        n_free_count = r_free_count;
        n_scan_idx   = r_scan_idx;
        n_remaining  = r_remaining;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        if (i_cmd.accept) begin
            if (i_in_data.cmd == pfba_pkg::CMD_FREE) begin
                // Release the frame if it was held, echo it either way
                if (r_used_map[i_in_data.frame_to_free]) begin
                    n_used_map[i_in_data.frame_to_free] = 1'b0;
                    n_free_count = r_free_count + 1'b1;
                end
                n_out.frame  = i_in_data.frame_to_free;
                n_out.status = pfba_pkg::ST_FREED;
                n_out.last   = 1'b1;
                n_out_valid  = 1'b1;
            end else if (i_in_data.page_count != '0) begin
                if (o_status.alloc_ok) begin
                    // Start the scan at the lowest frame
                    n_remaining = i_in_data.page_count;
                    n_scan_idx  = '0;
                end else begin
                    n_out.frame  = '0;
                    n_out.status = pfba_pkg::ST_NO_ROOM;
                    n_out.last   = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
        end

        if (i_cmd.step) begin
            // Test one frame per cycle while the output is not stalled, grant it if free
            n_scan_idx = r_scan_idx + 1'b1;
            if (w_scan_free) begin
                n_used_map[r_scan_idx] = 1'b1;
                n_free_count = r_free_count - 1'b1;
                n_remaining  = r_remaining - 1'b1;
                n_out.frame  = r_scan_idx;
                n_out.status = pfba_pkg::ST_GRANTED;
                n_out.last   = o_status.grant_last;
                n_out_valid  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_map   <= '0;
            r_free_count <= pfba_pkg::COUNT_W'(pfba_pkg::NUM_FRAMES);
            r_scan_idx   <= '0;
            r_remaining  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_used_map   <= n_used_map;
            r_free_count <= n_free_count;
            r_scan_idx   <= n_scan_idx;
            r_remaining  <= n_remaining;
            r_out_valid  <= n_out_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    `PFBA_ASSERT_NOW(a_count_matches_map, i_clk, i_rst_n, 1'b1, (32'(r_free_count) + 32'($countones(r_used_map)) == 32'(pfba_pkg::NUM_FRAMES)))
    `PFBA_ASSERT_NOW(a_grant_marked_used, i_clk, i_rst_n, (r_out_valid && (r_out.status == pfba_pkg::ST_GRANTED)), r_used_map[r_out.frame])
    `PFBA_ASSERT_NOW(a_step_has_work, i_clk, i_rst_n, i_cmd.step, (r_remaining != '0))
    `PFBA_ASSERT_NEXT(a_step_grants_on_free, i_clk, i_rst_n, (i_cmd.step && w_scan_free), (r_out_valid && (r_out.status == pfba_pkg::ST_GRANTED)))

endmodule

// ===== design/page_frame_bitmap_allocator.sv =====
// Page frame allocator: free request or rejection gives one result in the cycle after accept.
// Allocate of N pages scans one frame per cycle from frame 0 while the output is not stalled,
// granting each free frame it meets until N frames are granted.
// A new request is taken, one at a time, once the scan ends and the result register is free.
// Synchronous active-low reset: all frames free, free count NUM_FRAMES, no result pending.
module page_frame_bitmap_allocator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pfba_pkg::t_in_req   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pfba_pkg::t_out_res  o_out_data
);

    pfba_pkg::t_dp_cmd    w_cmd;
    pfba_pkg::t_dp_status w_status;

    // Sequence requests and scans
    pfba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Hold the bitmap and produce results
    pfba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
